>>> hw/rtl/frfs_pkg.sv
package frfs_pkg;

    localparam int unsigned IdxW  = 10;
    localparam int unsigned SizeW = 11;

    typedef enum logic {
        K_WRITE  = 1'b0,
        K_SEARCH = 1'b1
    } t_kind;

    typedef struct packed {
        logic             kind;
        logic [IdxW-1:0]  slot_index;
        logic             slot_busy;
        logic [SizeW-1:0] request_size;
    } t_in_item;

    typedef struct packed {
        logic            first_found;
        logic [IdxW-1:0] first_start;
        logic            best_found;
        logic [IdxW-1:0] best_start;
        logic            worst_found;
        logic [IdxW-1:0] worst_start;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/frfs_ram.sv
module frfs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/free_run_fit_search.sv
// Free-run fit search. The occupancy map sits in a RAM of (SLOTS+15)/16
// words of 16 bits. After reset a clearing pass writes zero to every word
// with busy high. A write item is a read-modify-write: busy is high for one
// cycle after the item is taken, while the word is written back, so a new
// item is only taken once the write is through. A search walks the map one
// slot per cycle, with the next 16-bit word read while the current one is
// scanned. One extra step closes a run at the map end and one more settles
// the result, with busy high throughout. o_valid pulses for one cycle with
// the result as busy drops, and the receiver cannot hold it off. Writes to a
// slot at or above SLOTS are ignored.
module free_run_fit_search #(
    parameter int unsigned SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  frfs_pkg::t_in_item  i_item,
    output logic                o_valid,
    output frfs_pkg::t_out_item o_item
);
    import frfs_pkg::*;

    localparam int unsigned WordW = 16;
    localparam int unsigned Words = (SLOTS + WordW - 1) / WordW;
    localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
    localparam int unsigned BitW  = $clog2(WordW);
    localparam int unsigned PosW  = $clog2(SLOTS + 1) + 1;

    t_state r_state, n_state;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [BitW-1:0]  r_bit, n_bit;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [PosW-1:0]  r_run, n_run;
    logic [PosW-1:0]  r_size;
    logic [IdxW-1:0]  r_idx;
    logic             r_bval;
    logic [WordW-1:0] r_word;
    logic             r_fitok;
    logic             r_ff, r_bf, r_wf;
    logic [PosW-1:0]  r_fs, r_bs, r_ws, r_blen, r_wlen;
    logic             r_valid;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [WordW-1:0] ram_wdata, ram_rdata;
    logic             r_loaded;

    frfs_ram #(.WIDTH(WordW), .DEPTH(Words)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic accept;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // scan step signals
    logic [WordW-1:0] cur_word;
    logic             cur_free, closing, fits;
    logic [PosW-1:0]  st;
    logic             last_bit;
    assign cur_word = r_loaded ? ram_rdata : r_word;
    assign cur_free = (r_pos < PosW'(SLOTS)) && !cur_word[r_bit];
    assign closing  = !cur_free && (r_run != '0);
    assign fits     = closing && r_fitok && (r_run >= r_size);
    assign st       = r_pos - r_run;
    assign last_bit = (r_pos == PosW'(SLOTS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_addr == AddrW'(Words - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_item.kind == K_SEARCH) ? S_SCAN : S_WRITE;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_SCAN:  if (last_bit) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = r_addr;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_pos     = r_pos;
        n_run     = r_run;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + AddrW'(1);
            end
            S_IDLE: begin
                n_addr    = AddrW'(i_item.slot_index >> BitW);
                ram_raddr = (i_item.kind == K_SEARCH) ? '0 : n_addr;
                if (i_item.kind == K_SEARCH) n_addr = '0;
                n_bit = '0;
                n_pos = '0;
                n_run = '0;
            end
            S_WRITE: begin
                ram_we    = (32'(r_idx) < 32'(SLOTS));
                ram_wdata = ram_rdata;
                ram_wdata[r_idx[BitW-1:0]] = r_bval;
            end
            S_SCAN: begin
                n_pos = r_pos + PosW'(1);
                n_bit = r_bit + BitW'(1);
                n_run = cur_free ? r_run + PosW'(1) : '0;
                if (r_bit == BitW'(WordW - 1)) begin
                    n_addr = r_addr + AddrW'(1);
                end
                // prefetch next word while scanning this one
                ram_raddr = r_addr + AddrW'(1);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_valid <= (r_state == S_DONE);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bit    <= n_bit;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_loaded <= 1'b0;
        if (r_state == S_IDLE && accept) begin
            r_idx    <= i_item.slot_index;
            r_bval   <= i_item.slot_busy;
            r_size   <= PosW'(i_item.request_size);
            r_fitok  <= (i_item.request_size != '0) &&
                        (32'(i_item.request_size) <= 32'(SLOTS));
            r_ff     <= 1'b0;
            r_bf     <= 1'b0;
            r_wf     <= 1'b0;
            r_fs     <= '0;
            r_bs     <= '0;
            r_ws     <= '0;
            r_blen   <= '0;
            r_wlen   <= '0;
            r_loaded <= 1'b1;
        end
        if (r_state == S_SCAN) begin
            r_word   <= cur_word;
            r_loaded <= (r_bit == BitW'(WordW - 1));
            if (fits) begin
                if (!r_ff) begin
                    r_ff <= 1'b1;
                    r_fs <= st;
                end
                if (!r_bf || r_run < r_blen) begin
                    r_bf   <= 1'b1;
                    r_bs   <= st;
                    r_blen <= r_run;
                end
                if (!r_wf || r_run > r_wlen) begin
                    r_wf   <= 1'b1;
                    r_ws   <= st;
                    r_wlen <= r_run;
                end
            end
        end
    end

    // result
    assign o_valid            = r_valid;
    assign o_item.first_found = r_ff;
    assign o_item.first_start = IdxW'(r_fs);
    assign o_item.best_found  = r_bf;
    assign o_item.best_start  = IdxW'(r_bs);
    assign o_item.worst_found = r_wf;
    assign o_item.worst_start = IdxW'(r_ws);

endmodule
